[src/mrpt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mrpt_pkg;

    // Field widths
    localparam int CAND_BITS        = 64;
    localparam int WORD_BITS_DFLT   = 64;

    // Witness bases: all fit in 31 bits
    localparam int BASE_BITS        = 31;
    localparam int NUM_BASES        = 7;
    localparam int BASE_IDX_W       = $clog2(NUM_BASES);

    // Trial-division primes 2..37
    localparam int NUM_SMALL        = 12;
    localparam int SP_BITS          = 6;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRIAL,
        S_CHECK,
        S_SPLIT,
        S_BASE,
        S_RED_WAIT,
        S_POW_SQ,
        S_SQ_WAIT,
        S_MULA_WAIT,
        S_POW_END,
        S_LOOP,
        S_LOOP_WAIT,
        S_NEXT,
        S_DONE
    } t_state;

    function automatic logic [BASE_BITS-1:0] mr_base(input logic [BASE_IDX_W-1:0] idx);
        logic [BASE_BITS-1:0] b;
        case (idx)
            3'd0:    b = 31'd2;
            3'd1:    b = 31'd325;
            3'd2:    b = 31'd9375;
            3'd3:    b = 31'd28178;
            3'd4:    b = 31'd450775;
            3'd5:    b = 31'd9780504;
            3'd6:    b = 31'd1795265022;
            default: b = 31'd2;
        endcase
        return b;
    endfunction

    function automatic logic [SP_BITS-1:0] small_prime(input int idx);
        logic [SP_BITS-1:0] p;
        case (idx)
            0:       p = 6'd2;
            1:       p = 6'd3;
            2:       p = 6'd5;
            3:       p = 6'd7;
            4:       p = 6'd11;
            5:       p = 6'd13;
            6:       p = 6'd17;
            7:       p = 6'd19;
            8:       p = 6'd23;
            9:       p = 6'd29;
            10:      p = 6'd31;
            11:      p = 6'd37;
            default: p = 6'd2;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

[src/mrpt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

// Candidate channel
interface mrpt_cand_if;
    import mrpt_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CAND_BITS-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

// Verdict channel
interface mrpt_flag_if;
    logic valid;
    logic ready;
    logic prime_flag;

    modport source (output valid, output prime_flag, input ready);
    modport sink   (input valid, input prime_flag, output ready);
endinterface

`default_nettype wire

[src/mrpt_mulmod.sv]
`timescale 1ns / 1ps
`default_nettype none

module mrpt_mulmod #(
    parameter int WORD_BITS = mrpt_pkg::WORD_BITS_DFLT
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [WORD_BITS-1:0]        i_x,
    input  wire logic [((WORD_BITS > mrpt_pkg::BASE_BITS) ? WORD_BITS
                                                       : mrpt_pkg::BASE_BITS)-1:0] i_y,
    input  wire logic [WORD_BITS-1:0]        i_mod,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [WORD_BITS-1:0]             o_prod
);
    import mrpt_pkg::*;

    localparam int W  = WORD_BITS;
    localparam int YW = (W > BASE_BITS) ? W : BASE_BITS;
    localparam int CW = $clog2(YW);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt,  n_cnt;
    logic [W-1:0]  r_acc,  n_acc;
    logic [W-1:0]  r_x,    n_x;
    logic [YW-1:0] r_y,    n_y;

    logic [W-1:0]  w_addend;
    logic [W+2:0]  w_sum, w_d1, w_d2;

    // One multiplier bit per cycle: acc = (2*acc + bit*x) mod m
    always_comb begin
        w_addend = r_y[YW-1] ? r_x : '0;
        w_sum    = {2'b00, r_acc, 1'b0} + {3'b000, w_addend};
        w_d1     = w_sum - {3'b000, i_mod};
        w_d2     = w_sum - {2'b00, i_mod, 1'b0};
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_acc  = r_acc;
        n_x    = r_x;
        n_y    = r_y;
        if (i_start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CW'(YW - 1);
            n_acc  = '0;
            n_x    = i_x;
            n_y    = i_y;
        end else if (r_busy) begin
            if (!w_d2[W+2]) begin
                n_acc = w_d2[W-1:0];
            end else if (!w_d1[W+2]) begin
                n_acc = w_d1[W-1:0];
            end else begin
                n_acc = w_sum[W-1:0];
            end
            n_y = {r_y[YW-2:0], 1'b0};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    // Clear control, keep payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_acc <= n_acc;
        r_x   <= n_x;
        r_y   <= n_y;
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

`default_nettype wire

[src/miller_rabin_prime_test_64.sv]
// Candidates below 2 or with a factor up to 37 finish after trial division; the others also run
// the Miller-Rabin rounds, whose run time is set by the bit-serial modular multiplier.
// Throughput: one item at a time; the next item is taken once the verdict is registered.
// Reset: synchronous, active low; clears the controller, the multiplier and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module miller_rabin_prime_test_64 #(
    parameter int WORD_BITS = mrpt_pkg::WORD_BITS_DFLT
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mrpt_cand_if.sink   i_cand,
    mrpt_flag_if.source o_res
);
    import mrpt_pkg::*;

    localparam int W     = WORD_BITS;
    localparam int YW    = (W > BASE_BITS) ? W : BASE_BITS;
    localparam int CNT_W = $clog2(W + 1);
    localparam int SW    = $clog2(W);

    t_state                r_state, n_state;
    logic [W-1:0]          r_n,     n_n;
    logic [W-1:0]          r_d,     n_d;
    logic [W-1:0]          r_e,     n_e;
    logic [W-1:0]          r_x,     n_x;
    logic [W-1:0]          r_a,     n_a;
    logic [CNT_W-1:0]      r_cnt,   n_cnt;
    logic [SW-1:0]         r_s,     n_s;
    logic [SW-1:0]         r_r,     n_r;
    logic [BASE_IDX_W-1:0] r_bi,    n_bi;
    logic [SP_BITS-1:0]    r_rem [NUM_SMALL];
    logic [SP_BITS-1:0]    n_rem [NUM_SMALL];
    logic                  r_flag,  n_flag;
    logic                  r_res_flag, n_res_flag;
    logic                  r_out_valid, n_out_valid;

    logic                  w_mul_start;
    logic [W-1:0]          w_mul_x;
    logic [YW-1:0]         w_mul_y;
    logic                  w_mul_busy;
    logic                  w_mul_done;
    logic [W-1:0]          w_mul_prod;

    logic [W-1:0]          w_nm1;
    logic                  w_any_zero;
    logic                  w_is_small;
    logic [SP_BITS:0]      w_two [NUM_SMALL];

    mrpt_mulmod #(
        .WORD_BITS (W)
    ) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_x     (w_mul_x),
        .i_y     (w_mul_y),
        .i_mod   (r_n),
        .o_busy  (w_mul_busy),
        .o_done  (w_mul_done),
        .o_prod  (w_mul_prod)
    );

    // Candidate is odd once the Miller-Rabin rounds run
    assign w_nm1 = {r_n[W-1:1], 1'b0};

    // Small-prime remainders, one candidate bit per cycle, MSB first
    always_comb begin
        w_any_zero = 1'b0;
        w_is_small = 1'b0;
        for (int k = 0; k < NUM_SMALL; k++) begin
            w_two[k] = {r_rem[k], r_d[W-1]};
            if (w_two[k] >= {1'b0, small_prime(k)}) begin
                w_two[k] = w_two[k] - {1'b0, small_prime(k)};
            end
            if (r_rem[k] == '0) begin
                w_any_zero = 1'b1;
            end
            if (r_n == W'(small_prime(k))) begin
                w_is_small = 1'b1;
            end
        end
    end

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_d         = r_d;
        n_e         = r_e;
        n_x         = r_x;
        n_a         = r_a;
        n_cnt       = r_cnt;
        n_s         = r_s;
        n_r         = r_r;
        n_bi        = r_bi;
        n_rem       = r_rem;
        n_flag      = r_flag;
        n_res_flag  = r_res_flag;
        n_out_valid = r_out_valid;
        w_mul_start = 1'b0;
        w_mul_x     = r_x;
        w_mul_y     = YW'(r_x);

        // Drop the verdict once taken
        if (o_res.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_cand.valid) begin
                    n_n   = i_cand.candidate[W-1:0];
                    n_d   = i_cand.candidate[W-1:0];
                    n_cnt = CNT_W'(W - 1);
                    for (int k = 0; k < NUM_SMALL; k++) begin
                        n_rem[k] = '0;
                    end
                    n_state = S_TRIAL;
                end
            end
            S_TRIAL: begin
                for (int k = 0; k < NUM_SMALL; k++) begin
                    n_rem[k] = w_two[k][SP_BITS-1:0];
                end
                n_d = {r_d[W-2:0], 1'b0};
                if (r_cnt == '0) begin
                    n_state = S_CHECK;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_CHECK: begin
                if (r_n[W-1:1] == '0) begin
                    n_flag  = 1'b0;
                    n_state = S_DONE;
                end else if (w_any_zero) begin
                    n_flag  = w_is_small;
                    n_state = S_DONE;
                end else begin
                    n_d     = w_nm1;
                    n_s     = '0;
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                // Strip factors of two from n-1
                if (!r_d[0]) begin
                    n_d = {1'b0, r_d[W-1:1]};
                    n_s = r_s + SW'(1);
                end else begin
                    n_bi    = '0;
                    n_state = S_BASE;
                end
            end
            S_BASE: begin
                // Reduce the base: 1 * base mod n
                w_mul_start = 1'b1;
                w_mul_x     = W'(1);
                w_mul_y     = YW'(mr_base(r_bi));
                n_state     = S_RED_WAIT;
            end
            S_RED_WAIT: begin
                if (w_mul_done) begin
                    if (w_mul_prod == '0) begin
                        n_state = S_NEXT;
                    end else begin
                        n_a     = w_mul_prod;
                        n_x     = W'(1);
                        n_e     = r_d;
                        n_cnt   = CNT_W'(W);
                        n_state = S_POW_SQ;
                    end
                end
            end
            S_POW_SQ: begin
                // Left-to-right exponentiation; squaring one is skipped
                if (r_cnt == '0) begin
                    n_state = S_POW_END;
                end else if (r_x == W'(1)) begin
                    if (r_e[W-1]) begin
                        n_x = r_a;
                    end
                    n_e   = {r_e[W-2:0], 1'b0};
                    n_cnt = r_cnt - CNT_W'(1);
                end else begin
                    w_mul_start = 1'b1;
                    w_mul_x     = r_x;
                    w_mul_y     = YW'(r_x);
                    n_state     = S_SQ_WAIT;
                end
            end
            S_SQ_WAIT: begin
                if (w_mul_done) begin
                    n_x = w_mul_prod;
                    if (r_e[W-1]) begin
                        w_mul_start = 1'b1;
                        w_mul_x     = r_a;
                        w_mul_y     = YW'(w_mul_prod);
                        n_state     = S_MULA_WAIT;
                    end else begin
                        n_e     = {r_e[W-2:0], 1'b0};
                        n_cnt   = r_cnt - CNT_W'(1);
                        n_state = S_POW_SQ;
                    end
                end
            end
            S_MULA_WAIT: begin
                if (w_mul_done) begin
                    n_x     = w_mul_prod;
                    n_e     = {r_e[W-2:0], 1'b0};
                    n_cnt   = r_cnt - CNT_W'(1);
                    n_state = S_POW_SQ;
                end
            end
            S_POW_END: begin
                if (r_x == W'(1) || r_x == w_nm1) begin
                    n_state = S_NEXT;
                end else begin
                    n_r     = SW'(1);
                    n_state = S_LOOP;
                end
            end
            S_LOOP: begin
                if (r_r < r_s) begin
                    w_mul_start = 1'b1;
                    w_mul_x     = r_x;
                    w_mul_y     = YW'(r_x);
                    n_state     = S_LOOP_WAIT;
                end else begin
                    n_flag  = 1'b0;
                    n_state = S_DONE;
                end
            end
            S_LOOP_WAIT: begin
                if (w_mul_done) begin
                    n_x = w_mul_prod;
                    if (w_mul_prod == w_nm1) begin
                        n_state = S_NEXT;
                    end else begin
                        n_r     = r_r + SW'(1);
                        n_state = S_LOOP;
                    end
                end
            end
            S_NEXT: begin
                if (r_bi == BASE_IDX_W'(NUM_BASES - 1)) begin
                    n_flag  = 1'b1;
                    n_state = S_DONE;
                end else begin
                    n_bi    = r_bi + BASE_IDX_W'(1);
                    n_state = S_BASE;
                end
            end
            S_DONE: begin
                // Hold until the output register is free, then load the verdict
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_res_flag  = r_flag;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_n        <= n_n;
        r_d        <= n_d;
        r_e        <= n_e;
        r_x        <= n_x;
        r_a        <= n_a;
        r_cnt      <= n_cnt;
        r_s        <= n_s;
        r_r        <= n_r;
        r_bi       <= n_bi;
        r_rem      <= n_rem;
        r_flag     <= n_flag;
        r_res_flag <= n_res_flag;
    end

    assign i_cand.ready     = (r_state == S_IDLE);
    assign o_res.valid      = r_out_valid;
    assign o_res.prime_flag = r_res_flag;

`ifndef SYNTHESIS
    a_accept_mul_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cand.valid && i_cand.ready) |-> !w_mul_busy)
        else $error("item accepted while the multiplier is busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (r_state == S_RED_WAIT || r_state == S_SQ_WAIT
                        || r_state == S_MULA_WAIT || r_state == S_LOOP_WAIT))
        else $error("product finished outside a wait state");

    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mul_done |-> (w_mul_prod < r_n))
        else $error("modular product not reduced");

    a_split_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOP) |-> (r_s != '0))
        else $error("squaring loop entered with zero power of two");
`endif

endmodule

`default_nettype wire
